// ===== sv/tlqe_pkg.sv =====
// Shared widths, stage records and vertex order for the thick line quad expander.
package tlqe_pkg;

    // Field widths
    localparam int COORD_W = 20;
    localparam int RAD_W   = 16;
    localparam int COL_W   = 32;
    localparam int POS_W   = 21;
    localparam int TEXX_W  = 17;
    localparam int TEXY_W  = 22;
    localparam int LEN_W   = 21;

    // Packed stream widths
    localparam int IN_W  = ((4 * COORD_W + 2 * RAD_W + 2 * COL_W + 7) / 8) * 8;
    localparam int VTX_W = 2 * POS_W + TEXX_W + TEXY_W + LEN_W + RAD_W + COL_W;
    localparam int OUT_W = ((VTX_W + 7) / 8) * 8;

    // Internal arithmetic widths
    localparam int EXTRA_W = 11;                     // extra fraction bits of the fine length
    localparam int DIFF_W  = COORD_W + 1;
    localparam int ABS_W   = COORD_W;
    localparam int SQ_W    = 2 * ABS_W + 1;
    localparam int BIG_W   = SQ_W + 2 * EXTRA_W;
    localparam int ROOT_W  = (BIG_W + 1) / 2;
    localparam int VAL_W   = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 3;
    localparam int N_W     = (SQ_W + 1) / 2;
    localparam int NSQ_W   = 2 * N_W;
    localparam int NUM_W   = ABS_W + RAD_W;
    localparam int DVD_W   = NUM_W + EXTRA_W + 2;
    localparam int DVS_W   = ROOT_W + 1;
    localparam int Q_W     = RAD_W + 1;
    localparam int DIR_W   = Q_W + 1;
    localparam int WIDE_W  = POS_W + 1;

    // Vertex order within one line
    localparam logic [2:0] V_BL  = 3'd0;
    localparam logic [2:0] V_BR  = 3'd1;
    localparam logic [2:0] V_TR  = 3'd2;
    localparam logic [2:0] V_TR2 = 3'd3;
    localparam logic [2:0] V_TL  = 3'd4;
    localparam logic [2:0] V_BL2 = 3'd5;

    // Line context carried down the pipe
    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic [RAD_W-1:0]          r1;
        logic [RAD_W-1:0]          r2;
        logic [COL_W-1:0]          c1;
        logic [COL_W-1:0]          c2;
        logic [RAD_W-1:0]          rmax;
        logic                      negx;
        logic                      negy;
        logic [ABS_W-1:0]          adx;
        logic [ABS_W-1:0]          ady;
    } t_ctx;

    // Square root stage
    typedef struct packed {
        t_ctx              ctx;
        logic [SQ_W-1:0]   sq;
        logic [VAL_W-1:0]  val;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqs;

    // Length and dividend setup stage
    typedef struct packed {
        t_ctx             ctx;
        logic [SQ_W-1:0]  sq;
        logic [N_W-1:0]   n;
        logic [NSQ_W-1:0] nsq;
        logic [DVS_W-1:0] fine;
        logic [NUM_W-1:0] numx;
        logic [NUM_W-1:0] numy;
    } t_lsu;

    // Divider stage, both directions side by side
    typedef struct packed {
        t_ctx             ctx;
        logic             zero;
        logic [LEN_W-1:0] len;
        logic [DVS_W-1:0] dvs;
        logic [DVD_W-1:0] remx;
        logic [DVD_W-1:0] remy;
        logic [Q_W-1:0]   qx;
        logic [Q_W-1:0]   qy;
    } t_dvs;

    // Signed direction stage
    typedef struct packed {
        t_ctx                    ctx;
        logic [LEN_W-1:0]        len;
        logic signed [DIR_W-1:0] dirx;
        logic signed [DIR_W-1:0] diry;
    } t_dir;

    // Quad geometry, ready to emit
    typedef struct packed {
        logic [POS_W-1:0]  blx;
        logic [POS_W-1:0]  bly;
        logic [POS_W-1:0]  brx;
        logic [POS_W-1:0]  bry;
        logic [POS_W-1:0]  trx;
        logic [POS_W-1:0]  tr_y;
        logic [POS_W-1:0]  tlx;
        logic [POS_W-1:0]  tly;
        logic [RAD_W-1:0]  rmax;
        logic [TEXY_W-1:0] top;
        logic [LEN_W-1:0]  len;
        logic [RAD_W-1:0]  r1;
        logic [RAD_W-1:0]  r2;
        logic [COL_W-1:0]  c1;
        logic [COL_W-1:0]  c2;
    } t_geo;

endpackage

// ===== sv/thick_line_quad_expander.sv =====
// Thick line to quad expander: pipelined length, direction and six-vertex emitter.
//
// Each accepted line produces six vertex items (BL, BR, TR, TR, TL, BL), one
// per cycle on the output while i_m_axis_tready holds, the last one flagged
// by tlast. The datapath is a stall-together pipeline of ROOT_W + Q_W + 8
// stages: operand setup, squaring, a one-bit-per-stage square root of the 63-bit
// scaled square, length rounding and dividend setup, a one-bit-per-stage divider
// for both direction components, sign restore, corner sums, then the emitter.
// Input is accepted whenever the last pipeline stage is empty or the emitter
// is taking its next line, so lines queue in the pipe while vertices drain.
module thick_line_quad_expander (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // start_x, start_y, end_x, end_y, start_radius, end_radius, start_color, end_color
    input  logic [tlqe_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // pos_x, pos_y, tex_x, tex_y, seg_length, vert_radius, vert_color, zero pad
    output logic [tlqe_pkg::OUT_W-1:0] o_m_axis_tdata,
    output logic                     o_m_axis_tlast
);

    localparam int CW = tlqe_pkg::COORD_W;
    localparam int RW = tlqe_pkg::RAD_W;
    localparam int KW = tlqe_pkg::COL_W;

    logic en;
    logic e_free;

    // ---------------- stage A: unpack, differences, larger radius
    tlqe_pkg::t_ctx n_a, r_a;
    logic           r_a_vld;
    logic signed [tlqe_pkg::DIFF_W-1:0] dx, dy;
    logic signed [tlqe_pkg::DIFF_W-1:0] mdx, mdy;

    always_comb begin
        n_a.sx   = i_s_axis_tdata[CW-1:0];
        n_a.sy   = i_s_axis_tdata[2*CW-1:CW];
        n_a.ex   = i_s_axis_tdata[3*CW-1:2*CW];
        n_a.ey   = i_s_axis_tdata[4*CW-1:3*CW];
        n_a.r1   = i_s_axis_tdata[4*CW+RW-1:4*CW];
        n_a.r2   = i_s_axis_tdata[4*CW+2*RW-1:4*CW+RW];
        n_a.c1   = i_s_axis_tdata[4*CW+2*RW+KW-1:4*CW+2*RW];
        n_a.c2   = i_s_axis_tdata[4*CW+2*RW+2*KW-1:4*CW+2*RW+KW];
        n_a.rmax = (n_a.r1 > n_a.r2) ? n_a.r1 : n_a.r2;
        dx       = {n_a.ex[CW-1], n_a.ex} - {n_a.sx[CW-1], n_a.sx};
        dy       = {n_a.ey[CW-1], n_a.ey} - {n_a.sy[CW-1], n_a.sy};
        n_a.negx = dx[tlqe_pkg::DIFF_W-1];
        n_a.negy = dy[tlqe_pkg::DIFF_W-1];
        mdx      = n_a.negx ? -dx : dx;
        mdy      = n_a.negy ? -dy : dy;
        n_a.adx  = mdx[tlqe_pkg::ABS_W-1:0];
        n_a.ady  = mdy[tlqe_pkg::ABS_W-1:0];
    end

    // ---------------- stage B: squares
    tlqe_pkg::t_ctx r_b;
    logic           r_b_vld;
    logic [2*tlqe_pkg::ABS_W-1:0] r_b_sqx, r_b_sqy;

    // ---------------- square root chain, stage 0 holds the scaled square
    tlqe_pkg::t_sqs n_sq [tlqe_pkg::ROOT_W+1];
    tlqe_pkg::t_sqs r_sq [tlqe_pkg::ROOT_W+1];
    logic [tlqe_pkg::ROOT_W:0] r_sq_vld;

    always_comb begin
        n_sq[0].ctx  = r_b;
        n_sq[0].sq   = tlqe_pkg::SQ_W'(r_b_sqx) + tlqe_pkg::SQ_W'(r_b_sqy);
        n_sq[0].val  = tlqe_pkg::VAL_W'(n_sq[0].sq) << (2 * tlqe_pkg::EXTRA_W);
        n_sq[0].rem  = '0;
        n_sq[0].root = '0;
    end

    // One result bit per stage: restoring digit-by-digit root
    for (genvar gi = 0; gi < tlqe_pkg::ROOT_W; gi++) begin : g_sqrt
        logic [tlqe_pkg::REM_W-1:0] pre, trial;
        always_comb begin
            pre   = {r_sq[gi].rem[tlqe_pkg::REM_W-3:0],
                     r_sq[gi].val[tlqe_pkg::VAL_W-1 -: 2]};
            trial = tlqe_pkg::REM_W'({r_sq[gi].root, 2'b01});
            n_sq[gi+1].ctx = r_sq[gi].ctx;
            n_sq[gi+1].sq  = r_sq[gi].sq;
            n_sq[gi+1].val = r_sq[gi].val << 2;
            if (pre >= trial) begin
                n_sq[gi+1].rem  = pre - trial;
                n_sq[gi+1].root = {r_sq[gi].root[tlqe_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_sq[gi+1].rem  = pre;
                n_sq[gi+1].root = {r_sq[gi].root[tlqe_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    // ---------------- stage L: coarse root squared, fine length, numerators
    tlqe_pkg::t_lsu n_l, r_l;
    logic           r_l_vld;

    always_comb begin
        n_l.ctx  = r_sq[tlqe_pkg::ROOT_W].ctx;
        n_l.sq   = r_sq[tlqe_pkg::ROOT_W].sq;
        n_l.n    = tlqe_pkg::N_W'(r_sq[tlqe_pkg::ROOT_W].root >> tlqe_pkg::EXTRA_W);
        n_l.nsq  = tlqe_pkg::NSQ_W'(n_l.n) * tlqe_pkg::NSQ_W'(n_l.n);
        // ceiling of the fine root
        n_l.fine = tlqe_pkg::DVS_W'(r_sq[tlqe_pkg::ROOT_W].root)
                 + tlqe_pkg::DVS_W'(r_sq[tlqe_pkg::ROOT_W].rem != '0);
        n_l.numx = tlqe_pkg::NUM_W'(n_l.ctx.adx) * tlqe_pkg::NUM_W'(n_l.ctx.rmax);
        n_l.numy = tlqe_pkg::NUM_W'(n_l.ctx.ady) * tlqe_pkg::NUM_W'(n_l.ctx.rmax);
    end

    // ---------------- divider chain, stage 0 holds rounded length and dividends
    tlqe_pkg::t_dvs n_dv [tlqe_pkg::Q_W+1];
    tlqe_pkg::t_dvs r_dv [tlqe_pkg::Q_W+1];
    logic [tlqe_pkg::Q_W:0] r_dv_vld;
    logic [tlqe_pkg::SQ_W:0] rsd;

    always_comb begin
        rsd          = (tlqe_pkg::SQ_W+1)'(r_l.sq) - (tlqe_pkg::SQ_W+1)'(r_l.nsq);
        n_dv[0].ctx  = r_l.ctx;
        n_dv[0].zero = (r_l.sq == '0);
        n_dv[0].len  = (rsd > (tlqe_pkg::SQ_W+1)'(r_l.n))
                     ? tlqe_pkg::LEN_W'(r_l.n) + 1'b1 : tlqe_pkg::LEN_W'(r_l.n);
        n_dv[0].dvs  = r_l.fine << 1;
        // (2 * num + fine) with num = |d| * R * 2^EXTRA
        n_dv[0].remx = (tlqe_pkg::DVD_W'(r_l.numx) << (tlqe_pkg::EXTRA_W + 1))
                     + tlqe_pkg::DVD_W'(r_l.fine);
        n_dv[0].remy = (tlqe_pkg::DVD_W'(r_l.numy) << (tlqe_pkg::EXTRA_W + 1))
                     + tlqe_pkg::DVD_W'(r_l.fine);
        n_dv[0].qx   = '0;
        n_dv[0].qy   = '0;
    end

    // One quotient bit per stage, most significant first
    for (genvar gk = 0; gk < tlqe_pkg::Q_W; gk++) begin : g_div
        localparam int B = tlqe_pkg::Q_W - 1 - gk;
        logic [tlqe_pkg::DVD_W-1:0] shd;
        always_comb begin
            shd = tlqe_pkg::DVD_W'(r_dv[gk].dvs) << B;
            n_dv[gk+1] = r_dv[gk];
            if (r_dv[gk].remx >= shd) begin
                n_dv[gk+1].remx  = r_dv[gk].remx - shd;
                n_dv[gk+1].qx[B] = 1'b1;
            end
            if (r_dv[gk].remy >= shd) begin
                n_dv[gk+1].remy  = r_dv[gk].remy - shd;
                n_dv[gk+1].qy[B] = 1'b1;
            end
        end
    end

    // ---------------- stage D: signed direction, zero for a degenerate line
    tlqe_pkg::t_dir n_d, r_d;
    logic           r_d_vld;
    logic signed [tlqe_pkg::DIR_W-1:0] qsx, qsy;

    always_comb begin
        qsx      = $signed({1'b0, r_dv[tlqe_pkg::Q_W].qx});
        qsy      = $signed({1'b0, r_dv[tlqe_pkg::Q_W].qy});
        n_d.ctx  = r_dv[tlqe_pkg::Q_W].ctx;
        n_d.len  = r_dv[tlqe_pkg::Q_W].len;
        if (r_dv[tlqe_pkg::Q_W].zero) begin
            n_d.dirx = '0;
            n_d.diry = '0;
        end else begin
            n_d.dirx = n_d.ctx.negx ? -qsx : qsx;
            n_d.diry = n_d.ctx.negy ? -qsy : qsy;
        end
    end

    // ---------------- stage G: corner positions
    tlqe_pkg::t_geo n_g, r_g;
    logic           r_g_vld;
    logic signed [tlqe_pkg::WIDE_W-1:0] wsx, wsy, wex, wey, wdx, wdy;
    logic signed [tlqe_pkg::WIDE_W-1:0] s_blx, s_bly, s_brx, s_bry;
    logic signed [tlqe_pkg::WIDE_W-1:0] s_trx, s_try, s_tlx, s_tly;

    always_comb begin
        wsx   = tlqe_pkg::WIDE_W'(r_d.ctx.sx);
        wsy   = tlqe_pkg::WIDE_W'(r_d.ctx.sy);
        wex   = tlqe_pkg::WIDE_W'(r_d.ctx.ex);
        wey   = tlqe_pkg::WIDE_W'(r_d.ctx.ey);
        wdx   = tlqe_pkg::WIDE_W'(r_d.dirx);
        wdy   = tlqe_pkg::WIDE_W'(r_d.diry);
        s_blx = wsx - wdy - wdx;
        s_bly = wsy + wdx - wdy;
        s_brx = wsx + wdy - wdx;
        s_bry = wsy - wdx - wdy;
        s_tlx = wex - wdy + wdx;
        s_tly = wey + wdx + wdy;
        s_trx = wex + wdy + wdx;
        s_try = wey - wdx + wdy;
        n_g.blx  = s_blx[tlqe_pkg::POS_W-1:0];
        n_g.bly  = s_bly[tlqe_pkg::POS_W-1:0];
        n_g.brx  = s_brx[tlqe_pkg::POS_W-1:0];
        n_g.bry  = s_bry[tlqe_pkg::POS_W-1:0];
        n_g.trx  = s_trx[tlqe_pkg::POS_W-1:0];
        n_g.tr_y = s_try[tlqe_pkg::POS_W-1:0];
        n_g.tlx  = s_tlx[tlqe_pkg::POS_W-1:0];
        n_g.tly  = s_tly[tlqe_pkg::POS_W-1:0];
        n_g.rmax = r_d.ctx.rmax;
        n_g.top  = tlqe_pkg::TEXY_W'(r_d.ctx.rmax) + tlqe_pkg::TEXY_W'(r_d.len);
        n_g.len  = r_d.len;
        n_g.r1   = r_d.ctx.r1;
        n_g.r2   = r_d.ctx.r2;
        n_g.c1   = r_d.ctx.c1;
        n_g.c2   = r_d.ctx.c2;
    end

    // ---------------- vertex emitter
    tlqe_pkg::t_geo r_e;
    logic           r_e_vld;
    logic [2:0]     r_cnt;

    assign e_free          = !r_e_vld || (i_m_axis_tready && r_cnt == tlqe_pkg::V_BL2);
    assign en              = !r_g_vld || e_free;
    assign o_s_axis_tready = en;

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_sq_vld <= '0;
            r_l_vld  <= 1'b0;
            r_dv_vld <= '0;
            r_d_vld  <= 1'b0;
            r_g_vld  <= 1'b0;
        end else if (en) begin
            r_a_vld  <= i_s_axis_tvalid;
            r_b_vld  <= r_a_vld;
            r_sq_vld <= {r_sq_vld[tlqe_pkg::ROOT_W-1:0], r_b_vld};
            r_l_vld  <= r_sq_vld[tlqe_pkg::ROOT_W];
            r_dv_vld <= {r_dv_vld[tlqe_pkg::Q_W-1:0], r_l_vld};
            r_d_vld  <= r_dv_vld[tlqe_pkg::Q_W];
            r_g_vld  <= r_d_vld;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a     <= n_a;
            r_b     <= r_a;
            r_b_sqx <= (2*tlqe_pkg::ABS_W)'(r_a.adx) * (2*tlqe_pkg::ABS_W)'(r_a.adx);
            r_b_sqy <= (2*tlqe_pkg::ABS_W)'(r_a.ady) * (2*tlqe_pkg::ABS_W)'(r_a.ady);
            r_l     <= n_l;
            r_d     <= n_d;
            r_g     <= n_g;
        end
    end

    for (genvar gs = 0; gs <= tlqe_pkg::ROOT_W; gs++) begin : g_sq_reg
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq[gs] <= n_sq[gs];
            end
        end
    end

    for (genvar gd = 0; gd <= tlqe_pkg::Q_W; gd++) begin : g_dv_reg
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[gd] <= n_dv[gd];
            end
        end
    end

    // Emitter control and line hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_cnt   <= tlqe_pkg::V_BL;
        end else if (e_free) begin
            r_e_vld <= r_g_vld;
            r_cnt   <= tlqe_pkg::V_BL;
        end else if (i_m_axis_tready) begin
            r_cnt <= r_cnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_free && r_g_vld) begin
            r_e <= r_g;
        end
    end

    // Vertex select
    logic [tlqe_pkg::POS_W-1:0]  v_px, v_py;
    logic signed [tlqe_pkg::TEXX_W-1:0] v_tx;
    logic [tlqe_pkg::TEXY_W-1:0] v_ty;
    logic [RW-1:0]               v_rad;
    logic [KW-1:0]               v_col;
    logic signed [tlqe_pkg::TEXX_W-1:0] rpos;
    logic [tlqe_pkg::TEXY_W-1:0] rneg_y;

    always_comb begin
        rpos   = $signed({1'b0, r_e.rmax});
        rneg_y = -tlqe_pkg::TEXY_W'(r_e.rmax);
        case (r_cnt)
            tlqe_pkg::V_BR: begin
                v_px = r_e.brx;  v_py = r_e.bry;
                v_tx = rpos;     v_ty = rneg_y;
                v_rad = r_e.r1;  v_col = r_e.c1;
            end
            tlqe_pkg::V_TR, tlqe_pkg::V_TR2: begin
                v_px = r_e.trx;  v_py = r_e.tr_y;
                v_tx = rpos;     v_ty = r_e.top;
                v_rad = r_e.r2;  v_col = r_e.c2;
            end
            tlqe_pkg::V_TL: begin
                v_px = r_e.tlx;  v_py = r_e.tly;
                v_tx = -rpos;    v_ty = r_e.top;
                v_rad = r_e.r2;  v_col = r_e.c2;
            end
            default: begin
                v_px = r_e.blx;  v_py = r_e.bly;
                v_tx = -rpos;    v_ty = rneg_y;
                v_rad = r_e.r1;  v_col = r_e.c1;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_e_vld;
    assign o_m_axis_tlast  = (r_cnt == tlqe_pkg::V_BL2);
    assign o_m_axis_tdata  = tlqe_pkg::OUT_W'({v_col, v_rad, r_e.len, v_ty, v_tx, v_py, v_px});

    // ---------------- checks
    // A line keeps going until its sixth vertex
    a_line_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=> o_m_axis_tvalid)
        else $error("vertex run cut short");

    // All vertices of a line share one length
    a_len_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast
        |=> $stable(o_m_axis_tdata[101:81]))
        else $error("segment length changed within a line");

    // A held pipe never drops the line waiting for the emitter
    a_pipe_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en && r_g_vld |=> r_g_vld)
        else $error("stalled line lost");

    // Vertex counter stays in its six codes
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= tlqe_pkg::V_BL2)
        else $error("vertex counter out of range");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the thick line quad expander: directed table, then random lines.
module tb;

    // Expected vertex item
    typedef struct {
        logic [tlqe_pkg::OUT_W-1:0] data;
        logic                       last;
    } t_vtx;

    // Directed line, with optional typed-in first vertex
    typedef struct {
        logic [tlqe_pkg::IN_W-1:0]  line;
        bit                         has_exp;
        logic [tlqe_pkg::OUT_W-1:0] exp0;
    } t_row;

    localparam int NUM_RAND  = 500;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 80;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_s_axis_tvalid;
    logic                       o_s_axis_tready;
    logic [tlqe_pkg::IN_W-1:0]  i_s_axis_tdata;
    logic                       o_m_axis_tvalid;
    logic                       i_m_axis_tready;
    logic [tlqe_pkg::OUT_W-1:0] o_m_axis_tdata;
    logic                       o_m_axis_tlast;

    t_vtx vtx_queue[$];
    t_row rows[$];
    int   fail_cnt = 0;
    int   idle_cyc = 0;
    bit   stim_done;
    bit   hold_rx;

    thick_line_quad_expander u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Pack one line item, start_x in the lowest bits
    function automatic logic [tlqe_pkg::IN_W-1:0] pack_line(int sx, int sy,
            int ex, int ey, int r1, int r2, logic [31:0] c1, logic [31:0] c2);
        logic [tlqe_pkg::IN_W-1:0] v;
        v = '0;
        v[4*tlqe_pkg::COORD_W+2*tlqe_pkg::RAD_W+2*tlqe_pkg::COL_W-1:0] =
            {c2, c1, 16'(r2), 16'(r1), 20'(ey), 20'(ex), 20'(sy), 20'(sx)};
        return v;
    endfunction

    function automatic logic [tlqe_pkg::OUT_W-1:0] pack_vtx(longint px, longint py,
            longint tx, longint ty, longint len, logic [15:0] rad, logic [31:0] col);
        logic [tlqe_pkg::OUT_W-1:0] v;
        logic [tlqe_pkg::POS_W-1:0] px_w, py_w;
        logic [tlqe_pkg::TEXX_W-1:0] tx_w;
        logic [tlqe_pkg::TEXY_W-1:0] ty_w;
        logic [tlqe_pkg::LEN_W-1:0] len_w;
        px_w  = tlqe_pkg::POS_W'(px);
        py_w  = tlqe_pkg::POS_W'(py);
        tx_w  = tlqe_pkg::TEXX_W'(tx);
        ty_w  = tlqe_pkg::TEXY_W'(ty);
        len_w = tlqe_pkg::LEN_W'(len);
        v = '0;
        v[tlqe_pkg::VTX_W-1:0] = {col, rad, len_w, ty_w, tx_w, py_w, px_w};
        return v;
    endfunction

    // Integer square root, floor
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    // Direction component scaled to radius, rounded half away from zero
    function automatic longint scale_dir(longint d, longint unsigned r, longint unsigned fine);
        longint unsigned mag, num, q;
        mag = d < 0 ? -d : d;
        num = (mag * r) << tlqe_pkg::EXTRA_W;
        q = (2 * num + fine) / (2 * fine);
        return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    // Six expected vertices for one line
    task automatic predict_quad(logic [tlqe_pkg::IN_W-1:0] line);
        longint sx, sy, ex, ey, dx, dy, r, dirx, diry, top;
        longint unsigned sq, n, len, big, fine;
        logic [15:0] r1, r2;
        logic [31:0] c1, c2;
        logic [tlqe_pkg::OUT_W-1:0] bl, br, tr, tl;
        sx = longint'($signed(line[19:0]));
        sy = longint'($signed(line[39:20]));
        ex = longint'($signed(line[59:40]));
        ey = longint'($signed(line[79:60]));
        r1 = line[95:80];
        r2 = line[111:96];
        c1 = line[143:112];
        c2 = line[175:144];
        r = longint'(r1 > r2 ? r1 : r2);
        dx = ex - sx;
        dy = ey - sy;
        sq = dx * dx + dy * dy;
        n = root_floor(sq);
        len = (sq - n * n > n) ? n + 1 : n;
        dirx = 0;
        diry = 0;
        if (sq != 0) begin
            big = sq << (2 * tlqe_pkg::EXTRA_W);
            fine = root_floor(big);
            if (fine * fine < big) fine++;
            dirx = scale_dir(dx, r, fine);
            diry = scale_dir(dy, r, fine);
        end
        top = r + longint'(len);
        bl = pack_vtx(sx - diry - dirx, sy + dirx - diry, -r, -r, len, r1, c1);
        br = pack_vtx(sx + diry - dirx, sy - dirx - diry, r, -r, len, r1, c1);
        tr = pack_vtx(ex + diry + dirx, ey - dirx + diry, r, top, len, r2, c2);
        tl = pack_vtx(ex - diry + dirx, ey + dirx + diry, -r, top, len, r2, c2);
        vtx_queue.push_back('{bl, 1'b0});
        vtx_queue.push_back('{br, 1'b0});
        vtx_queue.push_back('{tr, 1'b0});
        vtx_queue.push_back('{tr, 1'b0});
        vtx_queue.push_back('{tl, 1'b0});
        vtx_queue.push_back('{bl, 1'b1});
    endtask

    // Send one line: random gap with valid low, then hold valid until accepted
    task automatic send_line(logic [tlqe_pkg::IN_W-1:0] line, int gap);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= line;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_quad(line);
        @(negedge i_clk);
    endtask

    function automatic int rand_coord();
        case ($urandom_range(0, 3))
            0: return -524288 + int'($urandom_range(0, 3));
            1: return 524287 - int'($urandom_range(0, 3));
            2: return int'($urandom_range(0, 2047)) - 1024;
            default: return int'($signed(20'($urandom)));
        endcase
    endfunction

    function automatic int rand_rad();
        case ($urandom_range(0, 3))
            0: return 65535;
            1: return 0;
            default: return int'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [tlqe_pkg::IN_W-1:0] rand_line();
        int sx, sy;
        int r1;
        logic [31:0] c1;
        sx = rand_coord();
        sy = rand_coord();
        r1 = rand_rad();
        c1 = $urandom;
        // occasional zero length and single radius forms
        if ($urandom_range(0, 9) == 0) return pack_line(sx, sy, sx, sy, r1, rand_rad(), c1, $urandom);
        if ($urandom_range(0, 9) == 0) return pack_line(sx, sy, rand_coord(), rand_coord(),
                                                        r1, r1, c1, c1);
        return pack_line(sx, sy, rand_coord(), rand_coord(), r1, rand_rad(), c1, $urandom);
    endfunction

    // Directed table
    task automatic build_rows();
        // zero length at origin, zero radius: all zeros, first vertex typed in
        rows.push_back('{pack_line(0, 0, 0, 0, 0, 0, 0, 0), 1, '0});
        // zero length, radius 256: direction is zero, BL sits on the point
        rows.push_back('{pack_line(0, 0, 0, 0, 256, 256, 32'h11223344, 32'h55667788), 1,
                         pack_vtx(0, 0, -256, -256, 0, 16'd256, 32'h11223344)});
        // axis lines, both directions, then one slanted line
        rows.push_back('{pack_line(0, 0, 2560, 0, 256, 512, 32'hFF0000FF, 32'h00FF00FF), 0, '0});
        rows.push_back('{pack_line(0, 0, 0, -2560, 512, 256, 32'h12345678, 32'h9ABCDEF0), 0, '0});
        rows.push_back('{pack_line(100, 200, -300, 400, 1000, 1000, 32'hDEADBEEF,
                                   32'hDEADBEEF), 0, '0});
        // coordinate extremes, full and zero radii, assorted colors
        rows.push_back('{pack_line(-524288, -524288, 524287, 524287, 65535,
                                   65535, 32'hFFFFFFFF, 32'hFFFFFFFF), 0, '0});
        rows.push_back('{pack_line(524287, 524287, -524288, -524288, 65535,
                                   0, 32'h0, 32'hFFFFFFFF), 0, '0});
        rows.push_back('{pack_line(-524288, 524287, 524287, -524288, 0,
                                   65535, 32'hAAAAAAAA, 32'h55555555), 0, '0});
        rows.push_back('{pack_line(524287, -524288, 524287, -524288, 65535,
                                   65535, 32'h5A5A5A5A, 32'hA5A5A5A5), 0, '0});
        // one-unit steps and diagonals
        rows.push_back('{pack_line(0, 0, 1, 1, 1, 0, 1, 2), 0, '0});
        rows.push_back('{pack_line(0, 0, -1, 0, 0, 1, 3, 4), 0, '0});
        rows.push_back('{pack_line(5, 5, 5, 6, 32768, 32767, 5, 6), 0, '0});
        rows.push_back('{pack_line(-768, 1024, 768, -1024, 300, 299, 7, 8), 0, '0});
    endtask

    // Sender
    initial begin
        int k;
        logic [tlqe_pkg::IN_W-1:0] line;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_rst_n = 1'b0;
        stim_done = 1'b0;
        build_rows();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (k = 0; k < rows.size(); k++) begin
            if (rows[k].has_exp) begin
                // typed-in first vertex must match the prediction
                send_line(rows[k].line, $urandom_range(0, 7));
                if (vtx_queue[vtx_queue.size()-6].data !== rows[k].exp0) begin
                    $display("%0t row %0d typed vertex: expected %h actual %h", $realtime,
                             k, rows[k].exp0, vtx_queue[vtx_queue.size()-6].data);
                    fail_cnt++;
                end
            end else begin
                send_line(rows[k].line, $urandom_range(0, 7));
            end
        end
        for (k = 0; k < NUM_RAND; k++) begin
            line = rand_line();
            // a run of back-to-back lines now and then
            send_line(line, (k % 50 < 10) ? 0 : $urandom_range(0, 7));
            if (k == 250) begin
                // pause until all vertices are out
                i_s_axis_tvalid <= 1'b0;
                while (vtx_queue.size() != 0) @(negedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver, with one long hold-off
    initial begin
        int gap;
        int cyc;
        i_m_axis_tready = 1'b0;
        hold_rx = 1'b0;
        cyc = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc == 600) begin
                i_m_axis_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
            end
            gap = (cyc % 700 < 150) ? 0 : $urandom_range(0, 7);
            if (gap != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
        end
    end

    // Vertex checker
    always @(posedge i_clk) begin
        t_vtx exp_v;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (vtx_queue.size() == 0) begin
                $display("%0t unexpected vertex: expected none actual %h", $realtime,
                         o_m_axis_tdata);
                fail_cnt++;
            end else begin
                exp_v = vtx_queue.pop_front();
                if (o_m_axis_tdata !== exp_v.data) begin
                    $display("%0t vertex data: expected %h actual %h", $realtime,
                             exp_v.data, o_m_axis_tdata);
                    fail_cnt++;
                end
                if (o_m_axis_tlast !== exp_v.last) begin
                    $display("%0t vertex tlast: expected %b actual %b", $realtime,
                             exp_v.last, o_m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
    end

    // End of run
    initial begin
        fork
            begin
                wait (stim_done && vtx_queue.size() == 0);
                repeat (DRAIN_CYC) @(posedge i_clk);
                if (fail_cnt == 0 && vtx_queue.size() == 0)
                    $display("== PASS ==");
                else
                    $display("== FAIL ==");
            end
            begin
                wait (idle_cyc >= WDOG_MAX);
                $display("== FAIL ==");
            end
        join_any
        $finish;
    end
endmodule

// ===== sim.f =====
sv/tlqe_pkg.sv
sv/thick_line_quad_expander.sv
verif/tb.sv
